### rtl/core/block_free_list_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Block free list allocator: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BLOCK_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define BLOCK_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFLA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bfla_pkg.sv
// ----------------------------------------------------------------------------
// Block free list allocator package
// Sizes, state encoding and the command and status bundles shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bfla_pkg;

    localparam int NUM_BLOCKS    = 65536;
    localparam int PORTION       = 100;
    localparam int INDEX_W       = 16;
    localparam int INDEX_MAX     = (2 ** INDEX_W) - 1;
    localparam int HIGHEST_INDEX = ((NUM_BLOCKS - 1) > INDEX_MAX) ? INDEX_MAX
                                                                  : (NUM_BLOCKS - 1);
    localparam int LINK_DEPTH    = 2 ** INDEX_W;
    localparam int PTR_W         = $clog2(PORTION);
    localparam int CNT_W         = $clog2(PORTION + 1);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_FILL,
        ST_RESULT
    } bfla_state_t;

    typedef struct packed {
        logic accept;
        logic cache_pop;
        logic link_pop;
        logic fail;
        logic extend;
        logic free_push;
        logic free_link;
        logic take_read;
        logic fill_push;
        logic load_out;
    } bfla_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic is_free;
        logic idx_zero;
        logic cache_empty;
        logic cache_full;
        logic list_empty;
        logic no_space;
        logic fill_last;
        logic out_free;
    } bfla_sts_t;

endpackage

`default_nettype wire

### rtl/core/bfla_if.sv
// ----------------------------------------------------------------------------
// Block free list allocator channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfla_req_if;
    import bfla_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [INDEX_W-1:0] free_index;

    modport source (output valid, output command, output free_index, input ready);
    modport sink   (input valid, input command, input free_index, output ready);
endinterface

interface bfla_rsp_if;
    import bfla_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] granted_index;
    logic               status;

    modport source (output valid, output granted_index, output status, input ready);
    modport sink   (input valid, input granted_index, input status, output ready);
endinterface

`default_nettype wire

### rtl/core/bfla_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/bfla_datapath.sv
// ----------------------------------------------------------------------------
// Block free list allocator datapath
// Cache FIFO and link memories, list head, top index, pending result and
// the output register; acts on commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module bfla_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_command,
    input  wire logic [bfla_pkg::INDEX_W-1:0] in_free_index,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic      [bfla_pkg::INDEX_W-1:0] out_granted_index,
    output logic                             out_status,
    input  wire bfla_pkg::bfla_cmd_t         cmd,
    output bfla_pkg::bfla_sts_t              sts
);
    import bfla_pkg::*;

    logic [INDEX_W-1:0] list_head_reg, list_head_next;
    logic [INDEX_W-1:0] top_index_reg, top_index_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   fill_cnt_reg, fill_cnt_next;
    logic               rd_link_reg, rd_link_next;
    logic               out_valid_reg, out_valid_next;

    logic [INDEX_W-1:0] fill_val_reg, fill_val_next;
    logic [INDEX_W-1:0] res_index_reg, res_index_next;
    logic               res_status_reg, res_status_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic               out_status_reg, out_status_next;

    logic [INDEX_W:0]   new_top;
    logic               cache_we;
    logic [INDEX_W-1:0] cache_wdata;
    logic [INDEX_W-1:0] cache_rdata;
    logic [INDEX_W-1:0] link_rdata;

    assign new_top = {1'b0, top_index_reg} + (INDEX_W + 1)'(PORTION);

    always_comb
    begin
        sts.in_valid    = in_valid;
        sts.is_free     = (in_command == CMD_FREE);
        sts.idx_zero    = (in_free_index == '0);
        sts.cache_empty = (count_reg == '0);
        sts.cache_full  = (count_reg == CNT_W'(PORTION));
        sts.list_empty  = (list_head_reg == '0);
        sts.no_space    = (new_top > (INDEX_W + 1)'(HIGHEST_INDEX));
        sts.fill_last   = (fill_cnt_reg == CNT_W'(1));
        sts.out_free    = !out_valid_reg || out_ready;
    end

    assign cache_we    = cmd.free_push || cmd.fill_push;
    assign cache_wdata = cmd.free_push ? in_free_index : fill_val_reg;

    bfla_ram #(
        .WIDTH (INDEX_W),
        .DEPTH (PORTION)
    ) u_cache_ram (
        .clk   (clk),
        .we    (cache_we),
        .waddr (wr_ptr_reg),
        .wdata (cache_wdata),
        .re    (cmd.cache_pop),
        .raddr (rd_ptr_reg),
        .rdata (cache_rdata)
    );

    bfla_ram #(
        .WIDTH (INDEX_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (cmd.free_link),
        .waddr (in_free_index),
        .wdata (list_head_reg),
        .re    (cmd.link_pop),
        .raddr (list_head_reg),
        .rdata (link_rdata)
    );

    always_comb
    begin
        list_head_next  = list_head_reg;
        top_index_next  = top_index_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        count_next      = count_reg;
        fill_cnt_next   = fill_cnt_reg;
        rd_link_next    = rd_link_reg;
        out_valid_next  = out_valid_reg;
        fill_val_next   = fill_val_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;

        if (cmd.accept)
        begin
            res_index_next  = '0;
            res_status_next = STATUS_DONE;
        end

        if (cmd.cache_pop)
        begin
            rd_ptr_next  = (rd_ptr_reg == PTR_W'(PORTION - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next   = count_reg - 1'b1;
            rd_link_next = 1'b0;
        end

        if (cmd.link_pop)
        begin
            res_index_next = list_head_reg;
            rd_link_next   = 1'b1;
        end

        if (cmd.fail)
        begin
            res_status_next = STATUS_NO_SPACE;
        end

        if (cmd.extend)
        begin
            top_index_next = new_top[INDEX_W-1:0];
            res_index_next = new_top[INDEX_W-1:0];
            fill_val_next  = new_top[INDEX_W-1:0] - 1'b1;
            fill_cnt_next  = CNT_W'(PORTION - 1);
        end

        if (cache_we)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(PORTION - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end

        if (cmd.fill_push)
        begin
            fill_val_next = fill_val_reg - 1'b1;
            fill_cnt_next = fill_cnt_reg - 1'b1;
        end

        if (cmd.free_link)
        begin
            list_head_next = in_free_index;
        end

        if (cmd.take_read)
        begin
            if (rd_link_reg)
            begin
                list_head_next = link_rdata;
            end
            else
            begin
                res_index_next = cache_rdata;
            end
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next  = 1'b1;
            out_index_next  = res_index_reg;
            out_status_next = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_head_reg <= '0;
            top_index_reg <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            fill_cnt_reg  <= '0;
            rd_link_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            list_head_reg <= list_head_next;
            top_index_reg <= top_index_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            fill_cnt_reg  <= fill_cnt_next;
            rd_link_reg   <= rd_link_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_val_reg   <= fill_val_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid         = out_valid_reg;
    assign out_granted_index = out_index_reg;
    assign out_status        = out_status_reg;

endmodule

`default_nettype wire

### rtl/core/bfla_ctrl.sv
// ----------------------------------------------------------------------------
// Block free list allocator controller
// Sequences one word at a time: decode, memory read wait, cache fill after
// an extend, and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfla_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bfla_pkg::bfla_sts_t sts,
    output bfla_pkg::bfla_cmd_t      cmd,
    output logic                     in_ready
);
    import bfla_pkg::*;

    bfla_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!sts.is_free)
                    begin
                        if (!sts.cache_empty)
                        begin
                            cmd.cache_pop = 1'b1;
                            state_next    = ST_READ_WAIT;
                        end
                        else if (!sts.list_empty)
                        begin
                            cmd.link_pop = 1'b1;
                            state_next   = ST_READ_WAIT;
                        end
                        else if (sts.no_space)
                        begin
                            cmd.fail   = 1'b1;
                            state_next = ST_RESULT;
                        end
                        else
                        begin
                            cmd.extend = 1'b1;
                            state_next = ST_FILL;
                        end
                    end
                    else
                    begin
                        // A free of index zero is dropped; it only returns a result.
                        if (!sts.idx_zero)
                        begin
                            if (!sts.cache_full)
                            begin
                                cmd.free_push = 1'b1;
                            end
                            else
                            begin
                                cmd.free_link = 1'b1;
                            end
                        end
                        state_next = ST_RESULT;
                    end
                end
            end

            ST_READ_WAIT:
            begin
                cmd.take_read = 1'b1;
                state_next    = ST_RESULT;
            end

            ST_FILL:
            begin
                cmd.fill_push = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/block_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// Block free list allocator core
// Hands out and takes back block indexes from a FIFO cache, a linked free
// list kept in a per-block link memory, and a growing top index.
// ----------------------------------------------------------------------------
// One request word is handled at a time and each yields one response word.
// A free, an ignored free of index zero and a refused allocate go from decode
// straight to the result state; an allocate served from the cache or the free
// list passes through a read wait state for the registered read of the cache
// or link memory. An allocate that extends the top index writes PORTION-1 new
// indexes into the cache, one per cycle through its single write port, before
// its result is ready. The response sits in an output register, so a new
// request is taken while the previous response waits; a stalled response
// only holds the block once the next result is ready to be registered.
`default_nettype none

`include "block_free_list_allocator_core_macros.svh"

module block_free_list_allocator_core (
    input  wire logic clk,
    input  wire logic rst_n,
    bfla_req_if.sink  req,
    bfla_rsp_if.source rsp
);
    import bfla_pkg::*;

    bfla_cmd_t cmd;
    bfla_sts_t sts;
    logic      in_ready;

    bfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    bfla_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (req.valid),
        .in_command        (req.command),
        .in_free_index     (req.free_index),
        .out_ready         (rsp.ready),
        .out_valid         (rsp.valid),
        .out_granted_index (rsp.granted_index),
        .out_status        (rsp.status),
        .cmd               (cmd),
        .sts               (sts)
    );

    assign req.ready = in_ready;

    `BFLA_ASSERT_SAME(a_pop_not_empty, clk, rst_n, cmd.cache_pop, !sts.cache_empty, "cache pop while empty")
    `BFLA_ASSERT_SAME(a_push_not_full, clk, rst_n, cmd.free_push || cmd.fill_push, !sts.cache_full, "cache push while full")
    `BFLA_ASSERT_SAME(a_extend_when_dry, clk, rst_n, cmd.extend, sts.cache_empty && sts.list_empty, "extend with free indexes left")
    `BFLA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req.valid && req.ready, !req.ready, "second word taken while busy")

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block free list allocator core testbench
// Drives allocate and free words through the request channel with bursty
// timing, predicts every response word from a local copy of the cache, the
// linked free list and the top index, and checks each response in order.
// A directed opening is followed by a random mix that leans in turns toward
// allocating and toward freeing.
// ----------------------------------------------------------------------------
module tb_top;
    import bfla_pkg::*;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int RANDOM_WORDS  = 1130;
    localparam int HOLD_AT_WORD  = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUEUE_LEVEL   = 4;

    typedef struct packed {
        logic               command;
        logic [INDEX_W-1:0] free_index;
    } alloc_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0] granted_index;
        logic               status;
    } grant_t;

    logic clk;
    logic rst_n;

    bfla_req_if req ();
    bfla_rsp_if rsp ();

    block_free_list_allocator_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Local image of the allocator state.
    logic [INDEX_W-1:0] free_head;
    logic [INDEX_W-1:0] link_mem [LINK_DEPTH];
    logic [INDEX_W-1:0] cache_mem [PORTION];
    int                 cache_rd;
    int                 cache_wr;
    int                 cache_cnt;
    int                 top_idx;

    alloc_word_t        queued_words [$];
    grant_t             expected_grants [$];
    logic [INDEX_W-1:0] held_blocks [$];
    int                 mismatch_count;
    int                 cycle_count;

    int                 burst_left;
    int                 gap_left;
    logic [15:0]        stall_pattern;
    logic [3:0]         stall_phase;
    int                 taken_count;
    int                 hold_left;
    bit                 hold_done;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void cache_push(input logic [INDEX_W-1:0] idx);
        cache_mem[cache_wr] = idx;
        cache_wr = (cache_wr + 1) % PORTION;
        cache_cnt++;
    endfunction

    function automatic grant_t predict_grant(input alloc_word_t w);
        grant_t g;
        int     k;
        g.granted_index = '0;
        g.status = STATUS_DONE;
        if (w.command == CMD_ALLOC)
        begin
            if (cache_cnt > 0)
            begin
                g.granted_index = cache_mem[cache_rd];
                cache_rd = (cache_rd + 1) % PORTION;
                cache_cnt--;
            end
            else if (free_head != '0)
            begin
                g.granted_index = free_head;
                free_head = link_mem[free_head];
            end
            else if (top_idx + PORTION > HIGHEST_INDEX)
            begin
                g.status = STATUS_NO_SPACE;
            end
            else
            begin
                // The new top is granted; the rest of the portion goes to the
                // cache in descending order.
                for (k = top_idx + PORTION - 1; k > top_idx; k--)
                    cache_push(k[INDEX_W-1:0]);
                top_idx += PORTION;
                g.granted_index = top_idx[INDEX_W-1:0];
            end
        end
        else if (w.free_index != '0)
        begin
            if (cache_cnt < PORTION)
                cache_push(w.free_index);
            else
            begin
                link_mem[w.free_index] = free_head;
                free_head = w.free_index;
            end
        end
        return g;
    endfunction

    // Mostly gives back an index that is currently held, now and then a
    // foreign one.
    function automatic logic [INDEX_W-1:0] pick_free_index();
        int pos;
        logic [INDEX_W-1:0] idx;
        if (held_blocks.size() > 0 && $urandom_range(0, 19) != 0)
        begin
            pos = $urandom_range(0, held_blocks.size() - 1);
            idx = held_blocks[pos];
            held_blocks.delete(pos);
        end
        else
            idx = INDEX_W'($urandom_range(1, HIGHEST_INDEX));
        return idx;
    endfunction

    task automatic queue_word(input logic cmd, input logic [INDEX_W-1:0] idx);
        alloc_word_t w;
        w.command = cmd;
        w.free_index = idx;
        while (queued_words.size() >= QUEUE_LEVEL)
            @(posedge clk);
        queued_words.insert(queued_words.size(), w);
    endtask

    task automatic wait_drained();
        while (queued_words.size() != 0 || req.valid || expected_grants.size() != 0)
            @(posedge clk);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        alloc_word_t w;
        grant_t      g;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.command <= CMD_ALLOC;
            req.free_index <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                w.command = req.command;
                w.free_index = req.free_index;
                g = predict_grant(w);
                expected_grants.insert(expected_grants.size(), g);
                if (g.granted_index != '0)
                    held_blocks.insert(held_blocks.size(), g.granted_index);
            end
            if (!req.valid || req.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req.valid <= 1'b0;
                end
                else if (queued_words.size() > 0)
                begin
                    w = queued_words[0];
                    queued_words.delete(0);
                    req.valid <= 1'b1;
                    req.command <= w.command;
                    req.free_index <= w.free_index;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 40);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Response receiver: a rotating 16-bit ready pattern, plus one long
    // hold-off that backs the block up into its request channel.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_pattern = 16'hFFFF;
            stall_phase = '0;
            taken_count = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                taken_count++;
            if (!hold_done && taken_count >= HOLD_AT_WORD)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= stall_pattern[stall_phase];
            stall_phase = stall_phase + 1'b1;
            if (stall_phase == '0)
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                            : 16'($urandom | $urandom);
        end
    end

    // Response monitor.
    always @(posedge clk)
    begin
        grant_t g;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_grants.size() == 0)
            begin
                $display("%0t: response word with nothing expected, granted_index %0d status %0d",
                         $time, rsp.granted_index, rsp.status);
                mismatch_count++;
            end
            else
            begin
                g = expected_grants[0];
                expected_grants.delete(0);
                if (rsp.granted_index !== g.granted_index)
                begin
                    $display("%0t: granted_index mismatch, expected %0d, actual %0d",
                             $time, g.granted_index, rsp.granted_index);
                    mismatch_count++;
                end
                if (rsp.status !== g.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, g.status, rsp.status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int n;
        int free_share;
        rst_n = 1'b0;
        free_head = '0;
        cache_rd = 0;
        cache_wr = 0;
        cache_cnt = 0;
        top_idx = 0;
        mismatch_count = 0;
        cycle_count = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: first extend, cache pops, ignored free of zero,
        // frees at the ends of the index range and with alternating bits.
        queue_word(CMD_ALLOC, 16'hFFFF);
        queue_word(CMD_ALLOC, '0);
        queue_word(CMD_FREE, '0);
        queue_word(CMD_FREE, 16'hFFFF);
        queue_word(CMD_FREE, 16'h0001);
        queue_word(CMD_FREE, 16'h5555);
        queue_word(CMD_FREE, 16'hAAAA);
        queue_word(CMD_ALLOC, 16'h5555);
        queue_word(CMD_ALLOC, 16'hAAAA);
        queue_word(CMD_FREE, 16'd100);
        queue_word(CMD_FREE, 16'd99);
        queue_word(CMD_ALLOC, '0);
        queue_word(CMD_FREE, '0);
        queue_word(CMD_ALLOC, '0);
        wait_drained();

        // Random mix in segments that lean toward allocating or toward
        // freeing, so the cache drains into extends and overflows into the
        // linked list in turn.
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            free_share = ((n / 100) % 2 == 0) ? 25 : 75;
            if ($urandom_range(0, 99) < free_share)
            begin
                if ($urandom_range(0, 49) == 0)
                    queue_word(CMD_FREE, '0);
                else
                    queue_word(CMD_FREE, pick_free_index());
            end
            else
                queue_word(CMD_ALLOC, 16'($urandom));
        end
        wait_drained();
        repeat (PORTION + 20) @(posedge clk);

        if (expected_grants.size() != 0)
        begin
            $display("%0t: %0d expected response words never arrived",
                     $time, expected_grants.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
